// ===== src/ohlc_pkg.sv =====
// Shared types, constants and timeframe tables for the multi-timeframe OHLC bar builder.
// Has no dependencies. Every other file refers to it by scoped names.
package ohlc_pkg;

   localparam int NUM_TIMEFRAMES = 8;
   localparam int TF_BITS        = 3;
   localparam int DATE_BITS      = 27;
   localparam int HOUR_BITS      = 5;
   localparam int MINUTE_BITS    = 6;
   localparam int BAR_MIN_BITS   = 11;
   localparam int QTY_BITS       = 16;
   localparam int PERIOD_BITS    = 7;
   localparam int RECIP_BITS     = 13;
   localparam int RECIP_SHIFT    = 12;

   // Hour that wraps to midnight on the hourly timeframes.
   localparam logic [HOUR_BITS-1:0] HOUR_WRAP = 5'd24;

   // Timeframe indexes.
   localparam logic [TF_BITS-1:0] TF_1_MIN   = 3'd0;
   localparam logic [TF_BITS-1:0] TF_3_MIN   = 3'd1;
   localparam logic [TF_BITS-1:0] TF_5_MIN   = 3'd2;
   localparam logic [TF_BITS-1:0] TF_10_MIN  = 3'd3;
   localparam logic [TF_BITS-1:0] TF_15_MIN  = 3'd4;
   localparam logic [TF_BITS-1:0] TF_20_MIN  = 3'd5;
   localparam logic [TF_BITS-1:0] TF_60_MIN  = 3'd6;
   localparam logic [TF_BITS-1:0] TF_120_MIN = 3'd7;

   localparam logic [TF_BITS-1:0] TF_LAST = TF_BITS'(NUM_TIMEFRAMES - 1);

   typedef enum logic [1:0] {
      DIR_NEW  = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2,
      DIR_FLAT = 2'd3
   } dir_type;

   typedef struct packed {
      logic [DATE_BITS-1:0]    date;
      logic [BAR_MIN_BITS-1:0] minute;
   } key_type;

   function automatic logic [PERIOD_BITS-1:0] tf_period(input logic [TF_BITS-1:0] idx);
      logic [PERIOD_BITS-1:0] p;
      unique case (idx)
         TF_1_MIN:   p = 7'd1;
         TF_3_MIN:   p = 7'd3;
         TF_5_MIN:   p = 7'd5;
         TF_10_MIN:  p = 7'd10;
         TF_15_MIN:  p = 7'd15;
         TF_20_MIN:  p = 7'd20;
         TF_60_MIN:  p = 7'd60;
         TF_120_MIN: p = 7'd120;
      endcase
      return p;
   endfunction

   // ceil(2^12 / period), 0 if hourly; exact floor division for every 6-bit minute.
   function automatic logic [RECIP_BITS-1:0] tf_recip(input logic [TF_BITS-1:0] idx);
      logic [RECIP_BITS-1:0] r;
      unique case (idx)
         TF_1_MIN:   r = 13'd4096;
         TF_3_MIN:   r = 13'd1366;
         TF_5_MIN:   r = 13'd820;
         TF_10_MIN:  r = 13'd410;
         TF_15_MIN:  r = 13'd274;
         TF_20_MIN:  r = 13'd205;
         TF_60_MIN:  r = 13'd0;
         TF_120_MIN: r = 13'd0;
      endcase
      return r;
   endfunction

   function automatic logic tf_is_hourly(input logic [TF_BITS-1:0] idx);
      return (idx == TF_60_MIN) || (idx == TF_120_MIN);
   endfunction

endpackage

// ===== src/ohlc_start.sv =====
// Bar start unit: works out the start minute of the bar that a tick falls in.
// Two steps: quotient and hour base are registered, then start = base + quotient * period.
// Depends on ohlc_pkg.
module ohlc_start (
   input  logic                              clock,
   input  logic                              load,
   input  logic [ohlc_pkg::TF_BITS-1:0]      tf_index,
   input  logic [ohlc_pkg::HOUR_BITS-1:0]    hour,
   input  logic [ohlc_pkg::MINUTE_BITS-1:0]  minute,
   output logic [ohlc_pkg::BAR_MIN_BITS-1:0] start
);

   localparam int PROD_BITS = ohlc_pkg::MINUTE_BITS + ohlc_pkg::RECIP_BITS;
   localparam int SPAN_BITS = ohlc_pkg::MINUTE_BITS + ohlc_pkg::PERIOD_BITS;

   logic [ohlc_pkg::HOUR_BITS-1:0]    hour_adj;
   logic [PROD_BITS-1:0]              prod;
   logic [ohlc_pkg::MINUTE_BITS-1:0]  quot_in, quot_ff;
   logic [ohlc_pkg::BAR_MIN_BITS-1:0] base_in, base_ff;
   logic [SPAN_BITS-1:0]              span;
   logic [ohlc_pkg::BAR_MIN_BITS:0]   sum;

   always_comb begin
      hour_adj = hour;
      // The two-hour bar starts on an even hour.
      if (tf_index == ohlc_pkg::TF_120_MIN) begin
         hour_adj = hour & ~ohlc_pkg::HOUR_BITS'(1);
      end
      if (ohlc_pkg::tf_is_hourly(tf_index) && (hour_adj == ohlc_pkg::HOUR_WRAP)) begin
         hour_adj = '0;
      end
      // hour * 60 as a shift and subtract
      base_in = (ohlc_pkg::BAR_MIN_BITS'(hour_adj) << 6)
              - (ohlc_pkg::BAR_MIN_BITS'(hour_adj) << 2);
      prod    = PROD_BITS'(minute) * PROD_BITS'(ohlc_pkg::tf_recip(tf_index));
      quot_in = ohlc_pkg::tf_is_hourly(tf_index) ? '0
              : prod[ohlc_pkg::RECIP_SHIFT +: ohlc_pkg::MINUTE_BITS];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot_in;
         base_ff <= base_in;
      end
   end

   assign span  = SPAN_BITS'(quot_ff) * SPAN_BITS'(ohlc_pkg::tf_period(tf_index));
   assign sum   = {1'b0, base_ff} + (ohlc_pkg::BAR_MIN_BITS + 1)'(span);
   assign start = sum[ohlc_pkg::BAR_MIN_BITS-1:0];

endmodule

// ===== src/ohlc_update.sv =====
// Shared bar update unit: opens a new bar or folds a tick into the current one.
// Pure logic, used once per timeframe by the sequencer. Depends on ohlc_pkg.
module ohlc_update #(
   parameter int PRICE_BITS  = 48,
   parameter int VOLUME_BITS = 32
) (
   input  logic                           bar_valid,
   input  ohlc_pkg::key_type              cur_key,
   input  ohlc_pkg::key_type              prev_key,
   input  ohlc_pkg::key_type              tick_key,
   input  logic [PRICE_BITS-1:0]          price,
   input  logic [ohlc_pkg::QTY_BITS-1:0]  quantity,
   input  logic [PRICE_BITS-1:0]          bar_open,
   input  logic [PRICE_BITS-1:0]          bar_high,
   input  logic [PRICE_BITS-1:0]          bar_low,
   input  logic [VOLUME_BITS-1:0]         bar_volume,
   output ohlc_pkg::key_type              prev_key_in,
   output logic [PRICE_BITS-1:0]          open_in,
   output logic [PRICE_BITS-1:0]          high_in,
   output logic [PRICE_BITS-1:0]          low_in,
   output logic [VOLUME_BITS-1:0]         volume_in,
   output ohlc_pkg::dir_type              dir_in
);

   logic                 new_bar;
   logic [VOLUME_BITS:0] vol_sum;

   assign new_bar = !bar_valid || (cur_key != tick_key);
   assign vol_sum = {1'b0, bar_volume} + (VOLUME_BITS + 1)'(quantity);

   always_comb begin
      if (new_bar) begin
         // The key being replaced becomes the previous bar; none before the first bar.
         prev_key_in = bar_valid ? cur_key : '0;
         open_in     = price;
         high_in     = price;
         low_in      = price;
         volume_in   = VOLUME_BITS'(quantity);
         dir_in      = ohlc_pkg::DIR_NEW;
      end else begin
         prev_key_in = prev_key;
         open_in     = bar_open;
         high_in     = (price > bar_high) ? price : bar_high;
         low_in      = (price < bar_low) ? price : bar_low;
         volume_in   = vol_sum[VOLUME_BITS] ? '1 : vol_sum[VOLUME_BITS-1:0];
         if (price > bar_open) begin
            dir_in = ohlc_pkg::DIR_UP;
         end else if (price < bar_open) begin
            dir_in = ohlc_pkg::DIR_DOWN;
         end else begin
            dir_in = ohlc_pkg::DIR_FLAT;
         end
      end
   end

endmodule

// ===== src/multi_timeframe_ohlc_bar_builder.sv =====
// Channel   Direction  Handshake          Beat
// req_      in         req_valid/stall    one trade tick
// rsp_      out        rsp_valid/stall    one bar record, eight per tick
//
// A tick is taken only while the block is idle. Each timeframe then goes through
// the quotient step of the bar start unit, the bar update and the output
// register, in that order; a stalled record holds in the output register until
// rsp_stall falls. Reset is synchronous and clears all bars.
//
// Top level of the OHLC bar builder: tick register, sequencer, per-timeframe bar
// state and output register. Depends on ohlc_pkg, ohlc_start and ohlc_update.
module multi_timeframe_ohlc_bar_builder #(
   parameter int PRICE_BITS  = 48,
   parameter int VOLUME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ohlc_pkg::DATE_BITS-1:0]    req_date_code,
   input  logic [ohlc_pkg::HOUR_BITS-1:0]    req_hour,
   input  logic [ohlc_pkg::MINUTE_BITS-1:0]  req_minute,
   input  logic [PRICE_BITS-1:0]             req_price,
   input  logic [ohlc_pkg::QTY_BITS-1:0]     req_quantity,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ohlc_pkg::TF_BITS-1:0]      rsp_timeframe,
   output logic [ohlc_pkg::DATE_BITS-1:0]    rsp_bar_date,
   output logic [ohlc_pkg::BAR_MIN_BITS-1:0] rsp_bar_minute,
   output logic [ohlc_pkg::DATE_BITS-1:0]    rsp_prev_date,
   output logic [ohlc_pkg::BAR_MIN_BITS-1:0] rsp_prev_minute,
   output logic [PRICE_BITS-1:0]             rsp_open_price,
   output logic [PRICE_BITS-1:0]             rsp_high_price,
   output logic [PRICE_BITS-1:0]             rsp_low_price,
   output logic [PRICE_BITS-1:0]             rsp_close_price,
   output logic [VOLUME_BITS-1:0]            rsp_volume,
   output logic [1:0]                        rsp_direction,
   output logic                              rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_QUOT = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_OUT  = 4'b1000
   } seq_state_type;

   seq_state_type                     state_ff, state_in;
   logic [ohlc_pkg::TF_BITS-1:0]      idx_ff, idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Tick held for the whole sweep over the timeframes.
   logic [ohlc_pkg::DATE_BITS-1:0]    tick_date_ff;
   logic [ohlc_pkg::HOUR_BITS-1:0]    tick_hour_ff;
   logic [ohlc_pkg::MINUTE_BITS-1:0]  tick_minute_ff;
   logic [PRICE_BITS-1:0]             tick_price_ff;
   logic [ohlc_pkg::QTY_BITS-1:0]     tick_qty_ff;

   // Per-timeframe bar state.
   logic [ohlc_pkg::NUM_TIMEFRAMES-1:0] valid_ff;
   ohlc_pkg::key_type                 cur_key_ff  [ohlc_pkg::NUM_TIMEFRAMES];
   ohlc_pkg::key_type                 prev_key_ff [ohlc_pkg::NUM_TIMEFRAMES];
   logic [PRICE_BITS-1:0]             open_ff     [ohlc_pkg::NUM_TIMEFRAMES];
   logic [PRICE_BITS-1:0]             high_ff     [ohlc_pkg::NUM_TIMEFRAMES];
   logic [PRICE_BITS-1:0]             low_ff      [ohlc_pkg::NUM_TIMEFRAMES];
   logic [VOLUME_BITS-1:0]            volume_ff   [ohlc_pkg::NUM_TIMEFRAMES];

   // Output register.
   logic [ohlc_pkg::TF_BITS-1:0]      rsp_tf_ff;
   ohlc_pkg::key_type                 rsp_key_ff;
   ohlc_pkg::key_type                 rsp_prev_ff;
   logic [PRICE_BITS-1:0]             rsp_open_ff;
   logic [PRICE_BITS-1:0]             rsp_high_ff;
   logic [PRICE_BITS-1:0]             rsp_low_ff;
   logic [PRICE_BITS-1:0]             rsp_close_ff;
   logic [VOLUME_BITS-1:0]            rsp_volume_ff;
   ohlc_pkg::dir_type                 rsp_dir_ff;
   logic                              rsp_last_ff;

   logic                              req_take;
   logic                              start_load;
   logic [ohlc_pkg::BAR_MIN_BITS-1:0] start;
   ohlc_pkg::key_type                 tick_key;
   ohlc_pkg::key_type                 prev_key_in;
   logic [PRICE_BITS-1:0]             open_in;
   logic [PRICE_BITS-1:0]             high_in;
   logic [PRICE_BITS-1:0]             low_in;
   logic [VOLUME_BITS-1:0]            volume_in;
   ohlc_pkg::dir_type                 dir_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign start_load = (state_ff == ST_QUOT);

   ohlc_start u_start (
      .clock    (clock),
      .load     (start_load),
      .tf_index (idx_ff),
      .hour     (tick_hour_ff),
      .minute   (tick_minute_ff),
      .start    (start)
   );

   assign tick_key.date   = tick_date_ff;
   assign tick_key.minute = start;

   ohlc_update #(
      .PRICE_BITS  (PRICE_BITS),
      .VOLUME_BITS (VOLUME_BITS)
   ) u_update (
      .bar_valid   (valid_ff[idx_ff]),
      .cur_key     (cur_key_ff[idx_ff]),
      .prev_key    (prev_key_ff[idx_ff]),
      .tick_key    (tick_key),
      .price       (tick_price_ff),
      .quantity    (tick_qty_ff),
      .bar_open    (open_ff[idx_ff]),
      .bar_high    (high_ff[idx_ff]),
      .bar_low     (low_ff[idx_ff]),
      .bar_volume  (volume_ff[idx_ff]),
      .prev_key_in (prev_key_in),
      .open_in     (open_in),
      .high_in     (high_in),
      .low_in      (low_in),
      .volume_in   (volume_in),
      .dir_in      (dir_in)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idx_in   = '0;
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_QUOT;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_UPD) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_date_ff   <= req_date_code;
         tick_hour_ff   <= req_hour;
         tick_minute_ff <= req_minute;
         tick_price_ff  <= req_price;
         tick_qty_ff    <= req_quantity;
      end
      if (state_ff == ST_UPD) begin
         cur_key_ff[idx_ff]  <= tick_key;
         prev_key_ff[idx_ff] <= prev_key_in;
         open_ff[idx_ff]     <= open_in;
         high_ff[idx_ff]     <= high_in;
         low_ff[idx_ff]      <= low_in;
         volume_ff[idx_ff]   <= volume_in;

         rsp_tf_ff     <= idx_ff;
         rsp_key_ff    <= tick_key;
         rsp_prev_ff   <= prev_key_in;
         rsp_open_ff   <= open_in;
         rsp_high_ff   <= high_in;
         rsp_low_ff    <= low_in;
         rsp_close_ff  <= tick_price_ff;
         rsp_volume_ff <= volume_in;
         rsp_dir_ff    <= dir_in;
         rsp_last_ff   <= (idx_ff == ohlc_pkg::TF_LAST);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_timeframe   = rsp_tf_ff;
   assign rsp_bar_date    = rsp_key_ff.date;
   assign rsp_bar_minute  = rsp_key_ff.minute;
   assign rsp_prev_date   = rsp_prev_ff.date;
   assign rsp_prev_minute = rsp_prev_ff.minute;
   assign rsp_open_price  = rsp_open_ff;
   assign rsp_high_price  = rsp_high_ff;
   assign rsp_low_price   = rsp_low_ff;
   assign rsp_close_price = rsp_close_ff;
   assign rsp_volume      = rsp_volume_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== src/ohlc_checker.sv =====
// Port-level checks for the OHLC bar builder, attached to the top level by bind.
// Depends on ohlc_pkg and multi_timeframe_ohlc_bar_builder.
module ohlc_checker #(
   parameter int PRICE_BITS  = 48,
   parameter int VOLUME_BITS = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ohlc_pkg::TF_BITS-1:0]      rsp_timeframe,
   input logic [PRICE_BITS-1:0]             rsp_open_price,
   input logic [PRICE_BITS-1:0]             rsp_high_price,
   input logic [PRICE_BITS-1:0]             rsp_low_price,
   input logic [PRICE_BITS-1:0]             rsp_close_price,
   input logic [VOLUME_BITS-1:0]            rsp_volume,
   input logic [1:0]                        rsp_direction,
   input logic                              rsp_last
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_timeframe)
         && $stable(rsp_close_price) && $stable(rsp_volume))
      else $error("stalled result beat changed");

   // Once a tick is taken, no other is taken until its records are out.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("tick accepted while busy");

   // The final record of a tick frees the input side right away.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !req_stall && !rsp_valid)
      else $error("block not idle after final record");

   // Between records of one tick the next bar is still being built.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> !rsp_valid && req_stall)
      else $error("record sequence broken");

   // A freshly opened bar has all four prices equal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_direction == ohlc_pkg::DIR_NEW) |->
         (rsp_open_price == rsp_high_price) && (rsp_open_price == rsp_low_price)
         && (rsp_open_price == rsp_close_price))
      else $error("new bar prices differ");

endmodule

bind multi_timeframe_ohlc_bar_builder ohlc_checker #(
   .PRICE_BITS  (PRICE_BITS),
   .VOLUME_BITS (VOLUME_BITS)
) u_ohlc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_timeframe   (rsp_timeframe),
   .rsp_open_price  (rsp_open_price),
   .rsp_high_price  (rsp_high_price),
   .rsp_low_price   (rsp_low_price),
   .rsp_close_price (rsp_close_price),
   .rsp_volume      (rsp_volume),
   .rsp_direction   (rsp_direction),
   .rsp_last        (rsp_last)
);
